>>> design/sg2d_pkg.sv
// Shared types, constants and helper functions for the 2-D Savitzky-Golay smoother.
// Used by sg2d_divider and savitzky_golay_2d_smoother; depends on nothing else.
`default_nettype none
package sg2d_pkg;

    localparam int MaxRows    = 512;
    localparam int MaxCols    = 512;
    localparam int WinRadius  = 4;
    localparam int NumTaps    = 2 * WinRadius + 1;
    localparam int StoreDepth = MaxRows * MaxCols;
    localparam int AddrW      = $clog2(StoreDepth);

    // divider widths
    localparam int NumW  = 70;
    localparam int DenW  = 49;
    localparam int QuotW = 32;

    localparam logic [9:0] MaxDim = 10'd512;

    // command codes
    localparam logic CmdWrite = 1'b0;
    localparam logic CmdFetch = 1'b1;

    // status codes
    localparam logic [1:0] StatOk      = 2'd0;
    localparam logic [1:0] StatNoFrame = 2'd1;
    localparam logic [1:0] StatSumZero = 2'd2;

    typedef struct packed {
        logic            start;
        logic [NumW-1:0] num;
        logic [DenW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QuotW-1:0] quot;
    } t_div_rsp;

    function automatic logic signed [6:0] tap(input logic [3:0] k);
        logic signed [6:0] t;
        unique case (k)
            4'd0, 4'd8: t = -7'sd21;
            4'd1, 4'd7: t = 7'sd14;
            4'd2, 4'd6: t = 7'sd39;
            4'd3, 4'd5: t = 7'sd54;
            4'd4:       t = 7'sd59;
            default:    t = 7'sd0;
        endcase
        return t;
    endfunction

    // sum of the taps that fall inside [0, len)
    function automatic logic [8:0] tap_sum(input logic [9:0] pos, input logic [9:0] len);
        logic signed [11:0] p;
        logic signed [9:0]  s;
        s = '0;
        for (int k = 0; k < NumTaps; k++) begin
            p = $signed({2'b00, pos}) + 12'(k) - 12'(WinRadius);
            if (p >= 0 && p < $signed({2'b00, len})) begin
                s = s + 10'(tap(4'(k)));
            end
        end
        return s[8:0];
    endfunction

    function automatic logic [9:0] eff_dim(input logic [9:0] v);
        logic [9:0] d;
        if (v == 10'd0) begin
            d = 10'd1;
        end else if (v > MaxDim) begin
            d = MaxDim;
        end else begin
            d = v;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

>>> design/sg2d_divider.sv
// Restoring unsigned divider, one quotient bit per cycle, 32 quotient bits.
// Uses sg2d_pkg request/response structs; numerator must be below den * 2^32.
`default_nettype none
module sg2d_divider (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  sg2d_pkg::t_div_req i_req,
    output sg2d_pkg::t_div_rsp o_rsp
);

    localparam int ShW = sg2d_pkg::DenW + sg2d_pkg::QuotW - 1;

    logic [sg2d_pkg::NumW-1:0]  r_rem;
    logic [ShW-1:0]             r_dsh;
    logic [sg2d_pkg::QuotW-1:0] r_q;
    logic [5:0]                 r_cnt;
    logic                       r_done;
    logic                       w_ge;

    assign w_ge = {{(ShW - sg2d_pkg::NumW){1'b0}}, r_rem} >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem <= i_req.num;
                r_dsh <= {i_req.den, {(sg2d_pkg::QuotW - 1){1'b0}}};
                r_q   <= '0;
                r_cnt <= 6'(sg2d_pkg::QuotW);
            end else if (r_cnt != 6'd0) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh[sg2d_pkg::NumW-1:0];
                end
                r_q    <= {r_q[sg2d_pkg::QuotW-2:0], w_ge};
                r_dsh  <= r_dsh >> 1;
                r_cnt  <= r_cnt - 6'd1;
                r_done <= (r_cnt == 6'd1);
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule
`default_nettype wire

>>> design/savitzky_golay_2d_smoother.sv
// Top level of the 2-D Savitzky-Golay smoother: frame/result memories and pass sequencer.
// Depends on sg2d_pkg and sg2d_divider.
`default_nettype none
// A frame of frame_rows x frame_cols signed 16-bit samples is written in raster
// order (tuser 0), one beat per cycle while s_tready is high. The beat that fills
// the frame starts the smoothing run, during which s_tready stays low: a
// horizontal 9-tap pass, a vertical 9-tap pass with a divide by the valid tap
// weight, and a pass that scales every value by input_total / smoothed_total.
// Each pass walks the frame one element at a time through single-port-read
// memories, so the run is dominated by the shared 32-step divider (a saturated
// value skips the divide in the scaling pass, and a zero smoothed sum makes that
// pass write zero results). Fetch beats (tuser 1) then return one Q15.8 result
// each, in raster order, with one memory read per fetch; no beat is taken while
// a fetch result is pending. A fetch with no frame ready returns status 1.
// Results of a finished frame stay readable while the next frame loads, until
// that frame completes. Geometry registers live at byte address 0 (rows) and 4
// (cols); 0 acts as 1 and values above 512 act as 512.
module savitzky_golay_2d_smoother (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [15:0] sample
    input  wire  [0:0]  s_tuser,   // [0] command
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // [23:0] smoothed
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast,
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = sg2d_pkg::AddrW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HTAP  = 4'd1;
    localparam logic [3:0] S_HWR   = 4'd2;
    localparam logic [3:0] S_VINIT = 4'd3;
    localparam logic [3:0] S_VTAP  = 4'd4;
    localparam logic [3:0] S_VST   = 4'd5;
    localparam logic [3:0] S_VDIV  = 4'd6;
    localparam logic [3:0] S_NRD   = 4'd7;
    localparam logic [3:0] S_NM1   = 4'd8;
    localparam logic [3:0] S_NM2   = 4'd9;
    localparam logic [3:0] S_NSUM  = 4'd10;
    localparam logic [3:0] S_NCHK  = 4'd11;
    localparam logic [3:0] S_NDIV  = 4'd12;

    // memories: samples / scratch, and results / scratch
    logic [31:0] r_fmem [sg2d_pkg::StoreDepth];
    logic [31:0] r_smem [sg2d_pkg::StoreDepth];
    logic [31:0] r_fq;
    logic [31:0] r_sq;

    logic          f_we, s_we;
    logic [AW-1:0] f_wa, f_ra, s_wa, s_ra;
    logic [31:0]   f_wd, s_wd;

    // configuration
    logic [9:0] r_rows_cfg, r_cols_cfg;

    // control
    logic [3:0]  r_state;
    logic [AW:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0] r_len;
    logic        r_ready;
    logic signed [35:0] r_itot;
    logic signed [35:0] r_itl;
    logic signed [47:0] r_stot;

    // pass sequencing
    logic [9:0]    r_rows, r_cols;
    logic [AW-1:0] r_idx;
    logic [8:0]    r_row, r_col;
    logic [3:0]    r_k;
    logic signed [19:0] r_naddr;
    logic [16:0]   r_w;
    logic signed [34:0] r_acc;
    logic          r_pv;
    logic signed [6:0] r_ptap;
    logic          r_psrc;

    // normalize stage
    logic [25:0] r_smag;
    logic        r_neg;
    logic [43:0] r_plo, r_phi;
    logic [61:0] r_a;

    // fetch / output
    logic        r_pend, r_pok, r_plast;
    logic [1:0]  r_pstat;
    logic        r_mvalid;
    logic [23:0] r_mdata;
    logic [1:0]  r_muser;
    logic        r_mlast;

    sg2d_pkg::t_div_req w_dreq;
    sg2d_pkg::t_div_rsp w_drsp;

    sg2d_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    // ---------------------------------------------------------------- derived
    logic [9:0]  w_rows_e, w_cols_e;
    logic [19:0] w_size;
    logic        w_acc_in, w_is_wr;
    logic [AW:0] w_wp_nx;
    logic        w_out_free;
    logic        w_last_el;
    logic signed [11:0] w_tt, w_rr;
    logic        w_tt_ok, w_rr_ok;
    logic [AW:0] w_hadr;
    logic signed [25:0] w_pdata;
    logic signed [32:0] w_prod;
    logic [34:0] w_acc_abs;
    logic [35:0] w_itot_mag;
    logic [47:0] w_stot_mag;
    logic [25:0] w_fq_mag;
    logic        w_sat;
    logic [31:0] w_sq;
    logic [25:0] w_v;
    logic [23:0] w_res;

    assign w_rows_e   = sg2d_pkg::eff_dim(r_rows_cfg);
    assign w_cols_e   = sg2d_pkg::eff_dim(r_cols_cfg);
    assign w_size     = w_rows_e * w_cols_e;
    assign w_out_free = !r_mvalid || m_tready;
    assign w_is_wr    = (s_tuser[0] == sg2d_pkg::CmdWrite);
    assign s_tready   = (r_state == S_IDLE) && !r_pend && (w_is_wr || w_out_free);
    assign w_acc_in   = s_tvalid && s_tready;
    assign w_wp_nx    = r_wp + 1'b1;
    assign w_last_el  = ({1'b0, r_idx} == r_len - 1'b1);

    assign w_tt    = $signed({3'b000, r_col}) + $signed({8'd0, r_k}) - 12'sd4;
    assign w_rr    = $signed({3'b000, r_row}) + $signed({8'd0, r_k}) - 12'sd4;
    assign w_tt_ok = (w_tt >= 0) && (w_tt < $signed({2'b00, r_cols})) && (r_k < 4'd9);
    assign w_rr_ok = (w_rr >= 0) && (w_rr < $signed({2'b00, r_rows})) && (r_k < 4'd9);
    assign w_hadr  = {1'b0, r_idx} + {{(AW - 3){1'b0}}, r_k} - (AW + 1)'(4);

    assign w_pdata = r_psrc ? $signed(r_sq[25:0]) : 26'($signed(r_fq[15:0]));
    assign w_prod  = r_ptap * w_pdata;

    assign w_acc_abs  = r_acc[34] ? 35'(-r_acc) : 35'(r_acc);
    assign w_itot_mag = r_itl[35] ? 36'(-r_itl) : 36'(r_itl);
    assign w_stot_mag = r_stot[47] ? 48'(-r_stot) : 48'(r_stot);
    assign w_fq_mag   = r_fq[31] ? 26'(-$signed(r_fq)) : r_fq[25:0];
    assign w_sat      = {2'b00, r_a} >= {w_stot_mag, 16'd0};
    assign w_sq       = r_acc[34] ? (32'd0 - w_drsp.quot) : w_drsp.quot;
    assign w_v        = w_sat ? 26'h100_0000 : w_drsp.quot[25:0];

    // round-trip scaled value to Q15.8 with saturation
    always_comb begin
        if (r_neg) begin
            w_res = (w_v > 26'd8388608) ? 24'h80_0000 : 24'(26'd0 - w_v);
        end else begin
            w_res = (w_v > 26'd8388607) ? 24'h7F_FFFF : w_v[23:0];
        end
    end

    // divider requests
    always_comb begin
        w_dreq = '0;
        if (r_state == S_VST) begin
            w_dreq.start = 1'b1;
            w_dreq.num   = {27'd0, w_acc_abs[33:0], 9'd0} + {53'd0, r_w};
            w_dreq.den   = {31'd0, r_w, 1'b0};
        end else if (r_state == S_NCHK && !w_sat) begin
            w_dreq.start = 1'b1;
            w_dreq.num   = {r_a[60:0], 9'd0} + {22'd0, w_stot_mag};
            w_dreq.den   = {w_stot_mag, 1'b0};
        end
    end

    // memory port steering
    always_comb begin
        f_we = 1'b0;
        f_wa = r_wp[AW-1:0];
        f_wd = 32'($signed(s_tdata));
        f_ra = w_hadr[AW-1:0];
        s_we = 1'b0;
        s_wa = r_idx;
        s_wd = r_acc[31:0];
        s_ra = r_rp;
        unique case (r_state)
            S_IDLE: begin
                f_we = w_acc_in && w_is_wr;
            end
            S_HWR: begin
                s_we = 1'b1;
            end
            S_VTAP: begin
                s_ra = r_naddr[AW-1:0];
            end
            S_VDIV: begin
                f_we = w_drsp.done;
                f_wa = r_idx;
                f_wd = w_sq;
            end
            S_NRD: begin
                f_ra = r_idx;
                s_we = (r_stot == 48'sd0);
                s_wd = '0;
            end
            S_NCHK: begin
                s_we = w_sat;
                s_wd = 32'($signed(w_res));
            end
            S_NDIV: begin
                s_we = w_drsp.done;
                s_wd = 32'($signed(w_res));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            r_fmem[f_wa] <= f_wd;
        end
        r_fq <= r_fmem[f_ra];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_smem[s_wa] <= s_wd;
        end
        r_sq <= r_smem[s_ra];
    end

    // configuration port
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {22'd0, r_cols_cfg} : {22'd0, r_rows_cfg};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= sg2d_pkg::MaxDim;
            r_cols_cfg <= sg2d_pkg::MaxDim;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                r_cols_cfg <= pwdata[9:0];
            end else begin
                r_rows_cfg <= pwdata[9:0];
            end
        end
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wp     <= '0;
            r_rp     <= '0;
            r_len    <= '0;
            r_ready  <= 1'b0;
            r_itot   <= '0;
            r_stot   <= '0;
            r_pend   <= 1'b0;
            r_mvalid <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            r_pv <= 1'b0;
            if (r_pv) begin
                r_acc <= r_acc + 35'(w_prod);
            end

            // output register
            if (r_mvalid && m_tready) begin
                r_mvalid <= 1'b0;
            end
            if (r_pend) begin
                r_pend   <= 1'b0;
                r_mvalid <= 1'b1;
                r_mdata  <= r_pok ? r_sq[23:0] : 24'd0;
                r_muser  <= r_pok ? r_pstat : sg2d_pkg::StatNoFrame;
                r_mlast  <= r_pok && r_plast;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_acc_in && !w_is_wr) begin
                        r_pend  <= 1'b1;
                        r_pok   <= r_ready;
                        r_pstat <= (r_stot == 48'sd0) ? sg2d_pkg::StatSumZero
                                                      : sg2d_pkg::StatOk;
                        r_plast <= ({1'b0, r_rp} + 1'b1 == r_len);
                        if (r_ready) begin
                            if ({1'b0, r_rp} + 1'b1 >= r_len) begin
                                r_ready <= 1'b0;
                                r_rp    <= '0;
                            end else begin
                                r_rp <= r_rp + 1'b1;
                            end
                        end
                    end else if (w_acc_in) begin
                        if ({1'b0, w_wp_nx} >= w_size) begin
                            // frame complete: latch geometry and start the passes
                            r_itl   <= ({1'b0, r_wp} < w_size) ?
                                       r_itot + 36'($signed(s_tdata)) : r_itot;
                            r_itot  <= '0;
                            r_wp    <= '0;
                            r_rows  <= w_rows_e;
                            r_cols  <= w_cols_e;
                            r_len   <= w_size[AW:0];
                            r_ready <= 1'b0;
                            r_rp    <= '0;
                            r_stot  <= '0;
                            r_idx   <= '0;
                            r_row   <= '0;
                            r_col   <= '0;
                            r_k     <= '0;
                            r_acc   <= '0;
                            r_state <= S_HTAP;
                        end else begin
                            if ({1'b0, r_wp} < w_size) begin
                                r_itot <= r_itot + 36'($signed(s_tdata));
                            end
                            r_wp <= w_wp_nx;
                        end
                    end
                end

                // horizontal taps: samples -> smem
                S_HTAP: begin
                    if (w_tt_ok) begin
                        r_pv   <= 1'b1;
                        r_ptap <= sg2d_pkg::tap(r_k);
                        r_psrc <= 1'b0;
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == 4'd9) begin
                        r_state <= S_HWR;
                    end
                end

                S_HWR: begin
                    r_k   <= '0;
                    r_acc <= '0;
                    if (w_last_el) begin
                        r_idx   <= '0;
                        r_row   <= '0;
                        r_col   <= '0;
                        r_state <= S_VINIT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        if ({1'b0, r_col} == r_cols - 1'b1) begin
                            r_col <= '0;
                            r_row <= r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                        r_state <= S_HTAP;
                    end
                end

                // vertical taps: smem -> fmem, divided by valid weight
                S_VINIT: begin
                    r_naddr <= $signed({2'b00, r_idx}) - $signed({8'd0, r_cols, 2'b00});
                    r_w     <= 17'(sg2d_pkg::tap_sum({1'b0, r_row}, r_rows)
                                   * sg2d_pkg::tap_sum({1'b0, r_col}, r_cols));
                    r_k     <= '0;
                    r_acc   <= '0;
                    r_state <= S_VTAP;
                end

                S_VTAP: begin
                    if (w_rr_ok) begin
                        r_pv   <= 1'b1;
                        r_ptap <= sg2d_pkg::tap(r_k);
                        r_psrc <= 1'b1;
                    end
                    r_naddr <= r_naddr + $signed({10'd0, r_cols});
                    r_k     <= r_k + 1'b1;
                    if (r_k == 4'd9) begin
                        r_state <= S_VST;
                    end
                end

                S_VST: begin
                    r_state <= S_VDIV;
                end

                S_VDIV: begin
                    if (w_drsp.done) begin
                        r_stot <= r_stot + 48'($signed(w_sq));
                        if (w_last_el) begin
                            r_idx   <= '0;
                            r_state <= S_NRD;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                            if ({1'b0, r_col} == r_cols - 1'b1) begin
                                r_col <= '0;
                                r_row <= r_row + 1'b1;
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                            r_state <= S_VINIT;
                        end
                    end
                end

                // normalize: fmem -> smem
                S_NRD: begin
                    if (r_stot == 48'sd0) begin
                        if (w_last_el) begin
                            r_ready <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else begin
                        r_state <= S_NM1;
                    end
                end

                S_NM1: begin
                    r_smag  <= w_fq_mag;
                    r_neg   <= r_fq[31] ^ r_itl[35] ^ r_stot[47];
                    r_plo   <= w_fq_mag * w_itot_mag[17:0];
                    r_state <= S_NM2;
                end

                S_NM2: begin
                    r_phi   <= r_smag * w_itot_mag[35:18];
                    r_state <= S_NSUM;
                end

                S_NSUM: begin
                    r_a     <= {18'd0, r_plo} + {r_phi, 18'd0};
                    r_state <= S_NCHK;
                end

                S_NCHK, S_NDIV: begin
                    if ((r_state == S_NCHK && w_sat) || (r_state == S_NDIV && w_drsp.done)) begin
                        if (w_last_el) begin
                            r_ready <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_NRD;
                        end
                    end else if (r_state == S_NCHK) begin
                        r_state <= S_NDIV;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = r_mvalid;
    assign m_tdata  = r_mdata;
    assign m_tuser  = r_muser;
    assign m_tlast  = r_mlast;

`ifndef SYNTH
    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_tready)
        else $error("input accepted during a smoothing run");

    a_pend_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !r_mvalid)
        else $error("fetch result would overwrite a waiting beat");

    a_rp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> ({1'b0, r_rp} < r_len))
        else $error("read position beyond frame length");
`endif

endmodule
`default_nettype wire
